// ===== src/sabt_pkg.sv =====
// Shared widths, constants and types for the swept-box backout time block.
package sabt_pkg;

    localparam int NUM_W  = 25;   // distance magnitude, Q.8
    localparam int DEN_W  = 32;   // closing rate magnitude, Q.22
    localparam int REM_W  = DEN_W + 1;
    localparam int Q_W    = 31;   // time, Q17.14
    localparam int PRE_W  = 3;    // numerator bits that fall inside the quotient window
    localparam int DIV_LAT = Q_W + 1;

    localparam logic [Q_W-1:0] TIME_LIMIT = 31'd1638400000;

    localparam logic [1:0] EDGE_A_RIGHT  = 2'd0;
    localparam logic [1:0] EDGE_B_RIGHT  = 2'd1;
    localparam logic [1:0] EDGE_A_BOTTOM = 2'd2;
    localparam logic [1:0] EDGE_B_BOTTOM = 2'd3;

    typedef struct packed {
        logic           ok;
        logic [Q_W-1:0] q;
    } cand_t;

    typedef struct packed {
        logic           ok;
        logic [1:0]     idx;
        logic [Q_W-1:0] q;
    } best_t;

endpackage

// ===== src/sabt_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, candidate range check.
module sabt_divider (
    input  logic                        aclk,
    input  logic                        en,
    input  logic                        in_ok,
    input  logic [sabt_pkg::NUM_W-1:0]  in_num,
    input  logic [sabt_pkg::DEN_W-1:0]  in_den,
    output sabt_pkg::cand_t             cand
);

    localparam int NS = sabt_pkg::Q_W;

    logic [sabt_pkg::REM_W-1:0] rem_reg [0:NS];
    logic [sabt_pkg::DEN_W-1:0] den_reg [0:NS];
    logic [sabt_pkg::Q_W-1:0]   q_reg   [0:NS];
    logic [sabt_pkg::PRE_W-1:0] low_reg [0:NS];
    logic                       ok_reg  [0:NS];

    // Entry: quotient would reach 2^31 when num >> 3 >= den, which is past the limit anyway.
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= {{(sabt_pkg::REM_W-sabt_pkg::NUM_W+sabt_pkg::PRE_W){1'b0}},
                           in_num[sabt_pkg::NUM_W-1:sabt_pkg::PRE_W]};
            den_reg[0] <= in_den;
            q_reg[0]   <= '0;
            low_reg[0] <= in_num[sabt_pkg::PRE_W-1:0];
            ok_reg[0]  <= in_ok && ({{(sabt_pkg::DEN_W-sabt_pkg::NUM_W+sabt_pkg::PRE_W){1'b0}},
                           in_num[sabt_pkg::NUM_W-1:sabt_pkg::PRE_W]} < in_den);
        end
    end

    for (genvar j = 1; j <= NS; j++) begin : g_step
        localparam int K = NS - j;
        logic                       bit_in;
        logic [sabt_pkg::REM_W-1:0] trial;
        logic [sabt_pkg::REM_W-1:0] rem_next;
        logic                       qb;

        if (K >= sabt_pkg::Q_W - sabt_pkg::PRE_W) begin : g_pre
            assign bit_in = low_reg[j-1][K-(sabt_pkg::Q_W-sabt_pkg::PRE_W)];
        end else begin : g_zero
            assign bit_in = 1'b0;
        end

        always_comb begin
            trial = {rem_reg[j-1][sabt_pkg::REM_W-2:0], bit_in};
            qb    = trial >= {1'b0, den_reg[j-1]};
            rem_next = qb ? trial - {1'b0, den_reg[j-1]} : trial;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= rem_next;
                den_reg[j] <= den_reg[j-1];
                q_reg[j]   <= {q_reg[j-1][sabt_pkg::Q_W-2:0], qb};
                low_reg[j] <= low_reg[j-1];
                ok_reg[j]  <= ok_reg[j-1];
            end
        end
    end

    assign cand.ok = ok_reg[NS] && (q_reg[NS] != '0) && (q_reg[NS] < sabt_pkg::TIME_LIMIT);
    assign cand.q  = q_reg[NS];

endmodule

// ===== src/swept_aabb_backout_time.sv =====
// Top level: backout time of two overlapping axis-aligned boxes, fully pipelined.
//
// Input stream s_*: one box pair per request, fields packed in s_tdata.
// Output stream m_*: one result per pair, in order; time and edge in m_tdata,
// flags in m_tuser.
// Pipeline from an accepted request to m_tvalid: two stages of products and
// rates, 32 divider stages, one stage of minimum selection, output register.
// Throughput: one pair per cycle while the receiver does not stall the output;
// four bit-per-stage dividers run side by side, one for each box edge.
// The whole pipeline advances together; when the receiver holds m_tready low
// with a result waiting, every stage holds and s_tready drops, so nothing is
// lost or repeated. Empty stages are filled while the output is free.
// Reset (aresetn low, synchronous) clears all valid bits; data registers are
// not reset. Items with both closing rates zero report zero_rate_error.
module swept_aabb_backout_time (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_ax[23:0] pos_bx[47:24] pos_ay[71:48] pos_by[95:72] rate_a[111:96]
    // rate_b[127:112] dir_ax[143:128] dir_bx[159:144] dir_ay[175:160]
    // dir_by[191:176] size_a[223:192] size_b[255:224]
    input  logic [255:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // backout_time[30:0] edge_index[32:31], zero padding [39:33]
    output logic [39:0]  m_tdata,
    // found[0] zero_rate_error[1]
    output logic [1:0]   m_tuser
);

    localparam int NW = sabt_pkg::NUM_W;
    localparam int DW = sabt_pkg::DEN_W;
    localparam int DL = sabt_pkg::DIV_LAT;

    logic en;
    logic m_valid_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // field unpacking
    logic signed [23:0] pos_ax, pos_bx, pos_ay, pos_by;
    logic        [15:0] rate_a, rate_b;
    logic signed [15:0] dir_ax, dir_bx, dir_ay, dir_by;
    logic        [31:0] size_a, size_b;

    assign pos_ax = s_tdata[23:0];
    assign pos_bx = s_tdata[47:24];
    assign pos_ay = s_tdata[71:48];
    assign pos_by = s_tdata[95:72];
    assign rate_a = s_tdata[111:96];
    assign rate_b = s_tdata[127:112];
    assign dir_ax = s_tdata[143:128];
    assign dir_bx = s_tdata[159:144];
    assign dir_ay = s_tdata[175:160];
    assign dir_by = s_tdata[191:176];
    assign size_a = s_tdata[223:192];
    assign size_b = s_tdata[255:224];

    // stage 1: products and distances
    logic               v1_reg;
    logic signed [32:0] pax_reg, pbx_reg, pay_reg, pby_reg;
    logic signed [25:0] n_reg [0:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pax_reg <= $signed({1'b0, rate_a}) * dir_ax;
            pbx_reg <= $signed({1'b0, rate_b}) * dir_bx;
            pay_reg <= $signed({1'b0, rate_a}) * dir_ay;
            pby_reg <= $signed({1'b0, rate_b}) * dir_by;
            n_reg[0] <= 26'(pos_ax) - 26'(pos_bx) + $signed({2'b00, size_a[31:16], 4'b0});
            n_reg[1] <= 26'(pos_bx) - 26'(pos_ax) + $signed({2'b00, size_b[31:16], 4'b0});
            n_reg[2] <= 26'(pos_ay) - 26'(pos_by) + $signed({2'b00, size_a[15:0], 4'b0});
            n_reg[3] <= 26'(pos_by) - 26'(pos_ay) + $signed({2'b00, size_b[15:0], 4'b0});
        end
    end

    // stage 2: closing rates, magnitudes and sign tests
    logic signed [33:0] dvx, dvy;
    logic [DW-1:0]      dvx_abs, dvy_abs;
    logic [NW-1:0]      n_abs [0:3];
    logic               c_ok [0:3];
    logic               zero_err;

    logic               v2_reg;
    logic               z2_reg;
    logic               ok2_reg  [0:3];
    logic [NW-1:0]      num2_reg [0:3];
    logic [DW-1:0]      den2_reg [0:3];

    always_comb begin
        logic [33:0] tx, ty;
        logic [25:0] tn;
        dvx = 34'(pbx_reg) - 34'(pax_reg);
        dvy = 34'(pby_reg) - 34'(pay_reg);
        tx  = dvx[33] ? -dvx : dvx;
        ty  = dvy[33] ? -dvy : dvy;
        dvx_abs = tx[DW-1:0];
        dvy_abs = ty[DW-1:0];
        zero_err = (dvx == '0) && (dvy == '0);
        for (int i = 0; i < 4; i++) begin
            tn = n_reg[i][25] ? -n_reg[i] : n_reg[i];
            n_abs[i] = tn[NW-1:0];
        end
        // negated rate for the own-edge candidates: positive when rate is negative
        c_ok[0] = (n_reg[0] != '0) && (dvx != '0) && (n_reg[0][25] == !dvx[33]);
        c_ok[1] = (n_reg[1] != '0) && (dvx != '0) && (n_reg[1][25] == dvx[33]);
        c_ok[2] = (n_reg[2] != '0) && (dvy != '0) && (n_reg[2][25] == !dvy[33]);
        c_ok[3] = (n_reg[3] != '0) && (dvy != '0) && (n_reg[3][25] == dvy[33]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z2_reg <= zero_err;
            for (int i = 0; i < 4; i++) begin
                ok2_reg[i]  <= c_ok[i];
                num2_reg[i] <= n_abs[i];
            end
            den2_reg[0] <= dvx_abs;
            den2_reg[1] <= dvx_abs;
            den2_reg[2] <= dvy_abs;
            den2_reg[3] <= dvy_abs;
        end
    end

    // dividers
    sabt_pkg::cand_t cand [0:3];

    for (genvar i = 0; i < 4; i++) begin : g_div
        sabt_divider u_div (
            .aclk   (aclk),
            .en     (en),
            .in_ok  (ok2_reg[i]),
            .in_num (num2_reg[i]),
            .in_den (den2_reg[i]),
            .cand   (cand[i])
        );
    end

    // valid and error flag alongside the dividers
    logic vd_reg [0:DL-1];
    logic zd_reg [0:DL-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DL; i++) vd_reg[i] <= 1'b0;
        end else if (en) begin
            vd_reg[0] <= v2_reg;
            for (int i = 1; i < DL; i++) vd_reg[i] <= vd_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zd_reg[0] <= z2_reg;
            for (int i = 1; i < DL; i++) zd_reg[i] <= zd_reg[i-1];
        end
    end

    // pairwise minimum, lower edge wins ties
    function automatic sabt_pkg::best_t pick(sabt_pkg::best_t lo, sabt_pkg::best_t hi);
        sabt_pkg::best_t r;
        r = lo;
        if (hi.ok && (!lo.ok || hi.q < lo.q)) r = hi;
        return r;
    endfunction

    sabt_pkg::best_t c0, c1, c2, c3;
    assign c0 = '{ok: cand[0].ok, idx: sabt_pkg::EDGE_A_RIGHT,  q: cand[0].q};
    assign c1 = '{ok: cand[1].ok, idx: sabt_pkg::EDGE_B_RIGHT,  q: cand[1].q};
    assign c2 = '{ok: cand[2].ok, idx: sabt_pkg::EDGE_A_BOTTOM, q: cand[2].q};
    assign c3 = '{ok: cand[3].ok, idx: sabt_pkg::EDGE_B_BOTTOM, q: cand[3].q};

    logic            v3_reg, z3_reg;
    sabt_pkg::best_t bx_reg, by_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= vd_reg[DL-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z3_reg <= zd_reg[DL-1];
            bx_reg <= pick(c0, c1);
            by_reg <= pick(c2, c3);
        end
    end

    // output register
    sabt_pkg::best_t best;
    logic [sabt_pkg::Q_W-1:0] time_reg;
    logic [1:0]               edge_reg;
    logic                     found_reg, zerr_reg;

    assign best = pick(bx_reg, by_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            found_reg <= best.ok;
            zerr_reg  <= z3_reg;
            time_reg  <= best.ok ? best.q : '0;
            edge_reg  <= best.ok ? best.idx : sabt_pkg::EDGE_A_RIGHT;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, edge_reg, time_reg};
    assign m_tuser  = {zerr_reg, found_reg};

endmodule
